FILE: hdl/scb_pkg.sv
`default_nettype none

package scb_pkg;

  // Field widths
  localparam int ACTION_W = 8;
  localparam int Q_W      = 32;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 9;
  localparam int FRAC_W   = 16;

  // Default stack size
  localparam int SCB_STACK_DEPTH = 256;

  // Divider dividend: |a| << 16 plus half the divisor, one guard bit
  localparam int DIV_NUM_W = Q_W + FRAC_W + 1;

  // Opcodes
  localparam logic [ACTION_W-1:0] OP_CONST = 8'd0;
  localparam logic [ACTION_W-1:0] OP_ADD   = 8'd1;
  localparam logic [ACTION_W-1:0] OP_SUB   = 8'd2;
  localparam logic [ACTION_W-1:0] OP_MUL   = 8'd3;
  localparam logic [ACTION_W-1:0] OP_DIV   = 8'd4;
  localparam logic [ACTION_W-1:0] OP_NEG   = 8'd5;
  localparam logic [ACTION_W-1:0] OP_RET   = 8'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RET     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd5;

  localparam logic [Q_W-1:0] Q_MAX_BITS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN_BITS = 32'h8000_0000;

  // Controller to datapath commands
  typedef struct packed {
    logic                latch_in;
    logic                push;
    logic                read;
    logic                alu_commit;
    logic                mul_load;
    logic                mul_commit;
    logic                div_start;
    logic                div_commit;
    logic                neg;
    logic                ret;
    logic                reload;
    logic                report;
    logic [STATUS_W-1:0] report_code;
    logic                load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] op;
    logic                sp_zero;
    logic                sp_lt2;
    logic                sp_full;
    logic                top_zero;
    logic                div_done;
  } stat_t;

  // Apply sign to a magnitude and clamp to the Q16.16 range
  function automatic logic [Q_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [Q_W-1:0] res;
    if (neg) begin
      if (mag >= 64'h0000_0000_8000_0000) res = Q_MIN_BITS;
      else res = 32'd0 - mag[Q_W-1:0];
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) res = Q_MAX_BITS;
      else res = mag[Q_W-1:0];
    end
    return res;
  endfunction

  // Saturating add or subtract of two signed words
  function automatic logic [Q_W-1:0] add_sat(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b,
                                             input logic sub);
    logic [Q_W:0]   s;
    logic [Q_W-1:0] res;
    if (sub) s = {a[Q_W-1], a} - {b[Q_W-1], b};
    else s = {a[Q_W-1], a} + {b[Q_W-1], b};
    if (s[Q_W] != s[Q_W-1]) res = s[Q_W] ? Q_MIN_BITS : Q_MAX_BITS;
    else res = s[Q_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/scb_if.sv
`default_nettype none

interface scb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [scb_pkg::ACTION_W-1:0]  action;
  logic signed [scb_pkg::Q_W-1:0]       operand_value;

  modport source (output valid, output action, output operand_value, input ready);
  modport sink   (input valid, input action, input operand_value, output ready);
endinterface

interface scb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [scb_pkg::STATUS_W-1:0]  status;
  logic signed [scb_pkg::Q_W-1:0]       result_value;
  logic        [scb_pkg::DEPTH_W-1:0]   stack_depth;

  modport source (output valid, output status, output result_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input result_value, input stack_depth,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/scb_ram.sv
`default_nettype none

module scb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/scb_div.sv
`default_nettype none

module scb_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [scb_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [scb_pkg::Q_W-1:0]          den,
  output logic                                  done,
  output logic      [scb_pkg::DIV_NUM_W-1:0]    quot
);
  import scb_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [Q_W-1:0]       rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [Q_W-1:0]       den_r;

  logic [Q_W:0]         trial;
  logic [Q_W:0]         diff;
  logic                 ge;
  logic [Q_W-1:0]       rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial   = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

`default_nettype wire

FILE: hdl/scb_dpath.sv
`default_nettype none

module scb_dpath #(
  parameter int STACK_DEPTH = scb_pkg::SCB_STACK_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire scb_pkg::cmd_t                  cmd,
  output scb_pkg::stat_t                      st,
  input  wire logic [scb_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [scb_pkg::Q_W-1:0]        in_operand_value,
  output logic      [scb_pkg::STATUS_W-1:0]   out_status,
  output logic      [scb_pkg::Q_W-1:0]        out_result_value,
  output logic      [scb_pkg::DEPTH_W-1:0]    out_stack_depth
);
  import scb_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // Stack pointer counts entries; the top entry lives in top_r, the rest in RAM
  logic [SPW-1:0]       sp_r;
  logic [Q_W-1:0]       top_r;
  logic [ACTION_W-1:0]  op_r;
  logic [Q_W-1:0]       val_r;
  logic [63:0]          prod_r;
  logic                 sign_r;
  logic [STATUS_W-1:0]  res_status_r;
  logic [Q_W-1:0]       res_value_r;
  logic [DEPTH_W-1:0]   res_depth_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [Q_W-1:0]       out_value_r;
  logic [DEPTH_W-1:0]   out_depth_r;

  logic [SPW-1:0]       sp_m1;
  logic [SPW-1:0]       sp_m2;
  logic [SPW-1:0]       sp_p1;
  logic                 sp_zero;
  logic [Q_W-1:0]       rd_data;
  logic [Q_W-1:0]       a_mag;
  logic [Q_W-1:0]       b_mag;
  logic [63:0]          prod;
  logic [63:0]          rnd;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_NUM_W-1:0] quot;
  logic                 div_done;
  logic [Q_W-1:0]       neg_val;

  assign sp_m1   = sp_r - SPW'(1);
  assign sp_m2   = sp_r - SPW'(2);
  assign sp_p1   = sp_r + SPW'(1);
  assign sp_zero = (sp_r == '0);

  // Stack body below the top entry
  scb_ram #(
    .WIDTH (Q_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.push && !sp_zero),
    .wr_addr (sp_m1[AW-1:0]),
    .wr_data (top_r),
    .rd_en   (cmd.read),
    .rd_addr (sp_m2[AW-1:0]),
    .rd_data (rd_data)
  );

  // Operand magnitudes: a is the RAM entry below the top, b the top
  assign a_mag   = rd_data[Q_W-1] ? (32'd0 - rd_data) : rd_data;
  assign b_mag   = top_r[Q_W-1] ? (32'd0 - top_r) : top_r;
  assign prod    = {32'd0, a_mag} * {32'd0, b_mag};
  assign rnd     = prod_r + 64'h0000_0000_0000_8000;
  assign div_num = {1'b0, a_mag, 16'd0} + {18'd0, b_mag[Q_W-1:1]};
  assign neg_val = (top_r == Q_MIN_BITS) ? Q_MAX_BITS : (32'd0 - top_r);

  scb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (b_mag),
    .done  (div_done),
    .quot  (quot)
  );

  // Stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.push) begin
      sp_r <= sp_p1;
    end else if (cmd.alu_commit || cmd.mul_load || cmd.div_start || cmd.ret) begin
      sp_r <= sp_m1;
    end
  end

  // Top of stack, operands and result registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_action;
      val_r <= in_operand_value;
    end
    if (cmd.mul_load) begin
      prod_r <= prod;
    end
    if (cmd.mul_load || cmd.div_start) begin
      sign_r <= rd_data[Q_W-1] ^ top_r[Q_W-1];
    end
    if (cmd.reload) begin
      top_r <= rd_data;
    end
    if (cmd.push) begin
      top_r        <= val_r;
      res_status_r <= ST_OK;
      res_value_r  <= val_r;
      res_depth_r  <= DEPTH_W'(sp_p1);
    end
    if (cmd.alu_commit) begin
      top_r        <= add_sat(rd_data, top_r, op_r == OP_SUB);
      res_status_r <= ST_OK;
      res_value_r  <= add_sat(rd_data, top_r, op_r == OP_SUB);
      res_depth_r  <= DEPTH_W'(sp_m1);
    end
    if (cmd.mul_load || cmd.div_start) begin
      res_depth_r <= DEPTH_W'(sp_m1);
    end
    if (cmd.mul_commit) begin
      top_r        <= sat_mag(rnd >> FRAC_W, sign_r);
      res_status_r <= ST_OK;
      res_value_r  <= sat_mag(rnd >> FRAC_W, sign_r);
    end
    if (cmd.div_commit) begin
      top_r        <= sat_mag({15'd0, quot}, sign_r);
      res_status_r <= ST_OK;
      res_value_r  <= sat_mag({15'd0, quot}, sign_r);
    end
    if (cmd.neg) begin
      top_r        <= neg_val;
      res_status_r <= ST_OK;
      res_value_r  <= neg_val;
      res_depth_r  <= DEPTH_W'(sp_r);
    end
    if (cmd.ret) begin
      res_status_r <= ST_RET;
      res_value_r  <= top_r;
      res_depth_r  <= DEPTH_W'(sp_m1);
    end
    if (cmd.report) begin
      res_status_r <= cmd.report_code;
      res_value_r  <= sp_zero ? '0 : top_r;
      res_depth_r  <= DEPTH_W'(sp_r);
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_depth_r  <= res_depth_r;
    end
  end

  // Status to controller
  assign st.op       = op_r;
  assign st.sp_zero  = sp_zero;
  assign st.sp_lt2   = (sp_r < SPW'(2));
  assign st.sp_full  = (sp_r == SPW'(STACK_DEPTH));
  assign st.top_zero = (top_r == '0);
  assign st.div_done = div_done;

  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_stack_depth  = out_depth_r;

endmodule

`default_nettype wire

FILE: hdl/scb_ctrl.sv
`default_nettype none

module scb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire scb_pkg::stat_t  st,
  output scb_pkg::cmd_t        cmd
);
  import scb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_MULFIN,
    S_DIVWAIT,
    S_RELOAD,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Sequence one instruction through decode, operand read and commit
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_FIN;
        unique case (st.op) inside
          OP_CONST: begin
            if (st.sp_full) begin
              cmd.report      = 1'b1;
              cmd.report_code = ST_OVER;
            end else begin
              cmd.push = 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (st.sp_lt2) begin
              cmd.report      = 1'b1;
              cmd.report_code = ST_UNDER;
            end else if (st.op == OP_DIV && st.top_zero) begin
              cmd.report      = 1'b1;
              cmd.report_code = ST_DIVZERO;
            end else begin
              cmd.read  = 1'b1;
              state_nxt = S_READ;
            end
          end
          OP_NEG: begin
            if (st.sp_zero) begin
              cmd.report      = 1'b1;
              cmd.report_code = ST_UNDER;
            end else begin
              cmd.neg = 1'b1;
            end
          end
          OP_RET: begin
            if (st.sp_zero) begin
              cmd.report      = 1'b1;
              cmd.report_code = ST_UNDER;
            end else begin
              cmd.ret = 1'b1;
              // fetch the entry that becomes the new top
              if (!st.sp_lt2) begin
                cmd.read  = 1'b1;
                state_nxt = S_RELOAD;
              end
            end
          end
          default: begin
            cmd.report      = 1'b1;
            cmd.report_code = ST_UNKNOWN;
          end
        endcase
      end
      S_READ: begin
        unique case (st.op)
          OP_MUL: begin
            cmd.mul_load = 1'b1;
            state_nxt    = S_MULFIN;
          end
          OP_DIV: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIVWAIT;
          end
          default: begin
            cmd.alu_commit = 1'b1;
            state_nxt      = S_FIN;
          end
        endcase
      end
      S_MULFIN: begin
        cmd.mul_commit = 1'b1;
        state_nxt      = S_FIN;
      end
      S_DIVWAIT: begin
        if (st.div_done) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_RELOAD: begin
        cmd.reload = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/stack_calculator_bytecode_unit_core.sv
`default_nettype none

// Channel   Role    Beat contents
// in_bus    sink    action, operand_value (Q16.16 constant for a push)
// out_bus   source  status, result_value (Q16.16), stack_depth
//
// One instruction at a time: a push, negate, unknown opcode, any error and a
// return that empties the stack go from decode to finish; add, subtract and
// other returns also read or reload; multiply adds a registered 32x32 multiply;
// divide waits on the bit-serial divider (49 steps).
// The output register frees the core while a result waits to be taken; a result
// still waiting when the next one is done holds the core in its last state.
// Reset empties the stack; the stack memory needs no clearing pass.

module stack_calculator_bytecode_unit_core #(
  parameter int STACK_DEPTH = scb_pkg::SCB_STACK_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scb_in_if.sink      in_bus,
  scb_out_if.source   out_bus
);
  import scb_pkg::*;

  cmd_t  cmd;
  stat_t st;

  scb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .st        (st),
    .cmd       (cmd)
  );

  scb_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_action        (in_bus.action),
    .in_operand_value (in_bus.operand_value),
    .out_status       (out_bus.status),
    .out_result_value (out_bus.result_value),
    .out_stack_depth  (out_bus.stack_depth)
  );

endmodule

`default_nettype wire
